// ----- hdl/rnf_pkg.sv -----
// rnf_pkg: shared types, constants and helpers of the radix number formatter
// no dependencies; used by rnf_ctrl, rnf_dp and radix_number_formatter_unit
package rnf_pkg;

   localparam int MAX_DIGITS_DEFAULT = 10;
   localparam int FIELD_CAP          = 10;
   localparam int VALUE_WIDTH        = 32;
   localparam int FWIDTH_WIDTH       = 4;
   localparam int CHAR_WIDTH         = 7;
   localparam int DIGIT_WIDTH        = 4;

   // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int                     RECIP_SHIFT = 35;

   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE  = 7'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LETTER = 7'h57;

   typedef struct packed {
      logic load;
      logic extract;
      logic setup;
      logic emit;
   } rnf_cmd_type;

   typedef struct packed {
      logic ext_done;
      logic emit_done;
   } rnf_sts_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_glyph(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] ext;
      ext = CHAR_WIDTH'(d);
      if (d < 4'd10) begin
         digit_glyph = CHAR_ZERO + ext;
      end else begin
         digit_glyph = CHAR_LETTER + ext;
      end
   endfunction

endpackage

// ----- hdl/rnf_ctrl.sv -----
// rnf_ctrl: sequencing state machine of the radix number formatter
// depends on rnf_pkg; drives rnf_dp through command and status structs
module rnf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output rnf_pkg::rnf_cmd_type cmd,
   input  rnf_pkg::rnf_sts_type sts
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_EXTRACT = 2'd1;
   localparam logic [1:0] ST_SETUP   = 2'd2;
   localparam logic [1:0] ST_EMIT    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            cmd.extract = 1'b1;
            if (sts.ext_done) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/rnf_dp.sv -----
// rnf_dp: digit extraction, digit store and character output register
// depends on rnf_pkg; commanded by rnf_ctrl
module rnf_dp #(
   parameter int MAX_DIGITS = rnf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rnf_pkg::rnf_cmd_type                     cmd,
   output rnf_pkg::rnf_sts_type                     sts,
   input  logic [rnf_pkg::VALUE_WIDTH-1:0]          req_value,
   input  logic [rnf_pkg::FWIDTH_WIDTH-1:0]         req_field_width,
   input  logic                                    req_use_hex,
   input  logic                                    req_blank_leading_zeros,
   output logic                                    rsp_valid,
   output logic [rnf_pkg::CHAR_WIDTH-1:0]           rsp_character,
   output logic                                    rsp_last_char
);

   localparam int PW  = $clog2(MAX_DIGITS);
   localparam int WW  = $clog2(MAX_DIGITS + 1);
   localparam int CAP = (MAX_DIGITS < rnf_pkg::FIELD_CAP) ? MAX_DIGITS : rnf_pkg::FIELD_CAP;
   localparam int VW  = rnf_pkg::VALUE_WIDTH;
   localparam int DW  = rnf_pkg::DIGIT_WIDTH;
   localparam logic [WW-1:0] CAP_W  = WW'(CAP);
   localparam logic [PW-1:0] LAST_K = PW'(MAX_DIGITS - 1);

   logic [VW-1:0]                    num_ff;
   logic [PW-1:0]                    k_ff;
   logic [WW-1:0]                    sig_ff;
   logic [rnf_pkg::FWIDTH_WIDTH-1:0] fw_ff;
   logic                             hex_ff;
   logic                             blank_ff;
   logic [PW-1:0]                    pos_ff;
   logic [DW-1:0]                    digs_ff [MAX_DIGITS];
   logic                             rsp_valid_ff;
   logic [rnf_pkg::CHAR_WIDTH-1:0]   rsp_char_ff;
   logic                             rsp_last_ff;

   logic [2*VW-1:0]                  prod;
   logic [VW-1:0]                    quot10;
   logic [DW-1:0]                    q10_lo;
   logic [DW-1:0]                    digit;
   logic [VW-1:0]                    num_in;
   logic [WW-1:0]                    fw_ext;
   logic [WW-1:0]                    width_sel;
   logic [WW-1:0]                    width_in;
   logic [DW-1:0]                    cur_digit;
   logic                             cur_blank;
   logic [rnf_pkg::CHAR_WIDTH-1:0]   cur_char;

   // divide by ten through the reciprocal; remainder only needs four bits
   always_comb begin
      prod   = (2*VW)'(num_ff) * (2*VW)'(rnf_pkg::RECIP_TEN);
      quot10 = VW'(prod[2*VW-1:rnf_pkg::RECIP_SHIFT]);
      q10_lo = {quot10[0], 3'b000} + {quot10[2:0], 1'b0};
      if (hex_ff) begin
         digit  = num_ff[DW-1:0];
         num_in = num_ff >> DW;
      end else begin
         digit  = num_ff[DW-1:0] - q10_lo;
         num_in = quot10;
      end
   end

   // field width: zero selects significant digits, then saturate
   always_comb begin
      fw_ext    = WW'(fw_ff);
      width_sel = (fw_ff == '0) ? sig_ff : fw_ext;
      width_in  = (width_sel > CAP_W) ? CAP_W : width_sel;
   end

   always_comb begin
      cur_digit = digs_ff[pos_ff];
      cur_blank = blank_ff && (cur_digit == '0) && (pos_ff != '0);
      cur_char  = cur_blank ? rnf_pkg::CHAR_SPACE : rnf_pkg::digit_glyph(cur_digit);
   end

   assign sts.ext_done  = (k_ff == LAST_K);
   assign sts.emit_done = (pos_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff   <= req_value;
         fw_ff    <= req_field_width;
         hex_ff   <= req_use_hex;
         blank_ff <= req_blank_leading_zeros;
         k_ff     <= '0;
         sig_ff   <= WW'(1);
      end
      if (cmd.extract) begin
         num_ff <= num_in;
         k_ff   <= k_ff + PW'(1);
         if (digit != '0) begin
            sig_ff <= WW'(k_ff) + WW'(1);
         end
         // shift in from the top; units digit ends up in entry zero
         digs_ff[MAX_DIGITS-1] <= digit;
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            digs_ff[i] <= digs_ff[i+1];
         end
      end
      if (cmd.setup) begin
         pos_ff <= PW'(width_in - WW'(1));
      end
      if (cmd.emit) begin
         blank_ff    <= cur_blank;
         rsp_char_ff <= cur_char;
         rsp_last_ff <= (pos_ff == '0);
         if (pos_ff != '0) begin
            pos_ff <= pos_ff - PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   a_units_not_blanked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_character != rnf_pkg::CHAR_SPACE)
      else $error("units digit emitted as space");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |=> rsp_valid)
      else $error("character burst broken before last character");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |=> !rsp_valid)
      else $error("character emitted after last character");

   a_no_extract_while_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !cmd.extract && !cmd.load)
      else $error("overlapping datapath commands");

endmodule

// ----- hdl/radix_number_formatter_unit.sv -----
// radix_number_formatter_unit: top level of the radix number formatter
// depends on rnf_pkg, rnf_ctrl and rnf_dp
//
// A word is accepted when start is high and busy is low. The unit then makes one
// pass of the divide-by-radix step for every digit position, a setup step, and
// one emit step per character, w characters in all, w being the emitted field
// width (1 to 10 at the default MAX_DIGITS). Busy stays high until the last
// character is formed, so a new word is taken only after the last one is through.
// Characters come out most significant first on rsp_valid strobes in consecutive
// cycles, in the cycle after they are formed, the final one flagged by
// rsp_last_char. The receiver cannot stall: every strobed character must be taken.
module radix_number_formatter_unit #(
   parameter int MAX_DIGITS = rnf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [rnf_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic [rnf_pkg::FWIDTH_WIDTH-1:0] req_field_width,
   input  logic                             req_use_hex,
   input  logic                             req_blank_leading_zeros,
   output logic                             rsp_valid,
   output logic [rnf_pkg::CHAR_WIDTH-1:0]   rsp_character,
   output logic                             rsp_last_char
);

   rnf_pkg::rnf_cmd_type cmd;
   rnf_pkg::rnf_sts_type sts;

   rnf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   rnf_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_value               (req_value),
      .req_field_width         (req_field_width),
      .req_use_hex             (req_use_hex),
      .req_blank_leading_zeros (req_blank_leading_zeros),
      .rsp_valid               (rsp_valid),
      .rsp_character           (rsp_character),
      .rsp_last_char           (rsp_last_char)
   );

endmodule

// ----- verif/radix_format_checker.sv -----
// radix_format_checker: watches the request and character channels of the formatter,
// predicts the characters of every accepted word and compares them in order
// depends on rnf_pkg for widths and the space glyph
module radix_format_checker #(
   parameter int MAX_DIGITS = rnf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [rnf_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic [rnf_pkg::FWIDTH_WIDTH-1:0] req_field_width,
   input  logic                             req_use_hex,
   input  logic                             req_blank_leading_zeros,
   input  logic                             rsp_valid,
   input  logic [rnf_pkg::CHAR_WIDTH-1:0]   rsp_character,
   input  logic                             rsp_last_char,
   output int                               chars_outstanding,
   output int                               mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam string GLYPHS = "0123456789abcdef";
   localparam int    WIDTH_LIMIT = (MAX_DIGITS < rnf_pkg::FIELD_CAP) ?
                                   MAX_DIGITS : rnf_pkg::FIELD_CAP;

   typedef struct {
      logic [rnf_pkg::CHAR_WIDTH-1:0] character;
      logic                           last_char;
   } fmt_char_type;

   fmt_char_type expected_chars[$];

   initial begin
      mismatch_count    = 0;
      chars_outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 200) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic void format_number(input logic [rnf_pkg::VALUE_WIDTH-1:0] value,
                                         input logic [rnf_pkg::FWIDTH_WIDTH-1:0] field_width,
                                         input logic use_hex, input logic blank);
      logic [3:0]                      digits [MAX_DIGITS];
      logic [rnf_pkg::VALUE_WIDTH-1:0] rest;
      logic [rnf_pkg::VALUE_WIDTH-1:0] radix;
      int                              significant;
      int                              width;
      logic                            blanking;
      fmt_char_type                    c;
      rest        = value;
      radix       = use_hex ? 32'd16 : 32'd10;
      significant = 0;
      for (int pos = 0; pos < MAX_DIGITS; pos++) begin
         digits[pos] = 4'(rest % radix);
         rest        = rest / radix;
         if (digits[pos] != 4'd0 || pos == 0) begin
            significant = pos + 1;
         end
      end
      width = (field_width == 0) ? significant : int'(field_width);
      if (width > WIDTH_LIMIT) begin
         width = WIDTH_LIMIT;
      end
      blanking = blank;
      for (int pos = width - 1; pos >= 0; pos--) begin
         if (blanking && digits[pos] == 4'd0 && pos != 0) begin
            c.character = rnf_pkg::CHAR_SPACE;
         end else begin
            blanking    = 1'b0;
            c.character = rnf_pkg::CHAR_WIDTH'(GLYPHS[int'(digits[pos])]);
         end
         c.last_char = (pos == 0);
         expected_chars.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      fmt_char_type want;
      if (reset) begin
         expected_chars.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                         rsp_character, rsp_last_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.character) begin
                  report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            rsp_character, want.character));
               end
               if (rsp_last_char !== want.last_char) begin
                  report_mismatch($sformatf("last_char %0b, expected %0b",
                                            rsp_last_char, want.last_char));
               end
            end
         end
         if (start && !busy) begin
            format_number(req_value, req_field_width, req_use_hex, req_blank_leading_zeros);
         end
      end
      chars_outstanding <= expected_chars.size();
   end

endmodule

// ----- verif/tb.sv -----
// tb: top of the radix number formatter testbench; drives directed and random words
// into radix_number_formatter_unit and gives the verdict
// depends on rnf_pkg, radix_number_formatter_unit and radix_format_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 400;
   localparam int RANDOM_WORDS = 98;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [rnf_pkg::VALUE_WIDTH-1:0]  req_value;
   logic [rnf_pkg::FWIDTH_WIDTH-1:0] req_field_width;
   logic                             req_use_hex;
   logic                             req_blank_leading_zeros;
   logic                             rsp_valid;
   logic [rnf_pkg::CHAR_WIDTH-1:0]   rsp_character;
   logic                             rsp_last_char;
   int                               chars_outstanding;
   int                               mismatch_count;
   int                               idle_cycles;
   logic                             back_to_back;

   radix_number_formatter_unit u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_value               (req_value),
      .req_field_width         (req_field_width),
      .req_use_hex             (req_use_hex),
      .req_blank_leading_zeros (req_blank_leading_zeros),
      .rsp_valid               (rsp_valid),
      .rsp_character           (rsp_character),
      .rsp_last_char           (rsp_last_char)
   );

   radix_format_checker u_check (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_value               (req_value),
      .req_field_width         (req_field_width),
      .req_use_hex             (req_use_hex),
      .req_blank_leading_zeros (req_blank_leading_zeros),
      .rsp_valid               (rsp_valid),
      .rsp_character           (rsp_character),
      .rsp_last_char           (rsp_last_char),
      .chars_outstanding       (chars_outstanding),
      .mismatch_count          (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // busy only moves at rising edges, so its value at the falling edge holds for the next one
   task automatic send_word(input logic [rnf_pkg::VALUE_WIDTH-1:0] value,
                            input logic [rnf_pkg::FWIDTH_WIDTH-1:0] field_width,
                            input logic use_hex, input logic blank);
      int   gap;
      logic taken;
      gap = back_to_back ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                   <= 1'b1;
      req_value               <= value;
      req_field_width         <= field_width;
      req_use_hex             <= use_hex;
      req_blank_leading_zeros <= blank;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain_chars();
      logic empty;
      start <= 1'b0;
      do begin
         @(negedge clock);
         empty = (chars_outstanding == 0);
         @(posedge clock);
      end while (!empty);
   endtask

   initial begin
      logic [rnf_pkg::VALUE_WIDTH-1:0]  value;
      logic [rnf_pkg::FWIDTH_WIDTH-1:0] field_width;
      longint                           scaled;
      reset                   = 1'b1;
      start                   = 1'b0;
      req_value               = '0;
      req_field_width         = '0;
      req_use_hex             = 1'b0;
      req_blank_leading_zeros = 1'b0;
      idle_cycles             = 0;
      back_to_back            = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_word(32'd0, 4'd0, 1'b0, 1'b0);
      send_word(32'd0, 4'd0, 1'b1, 1'b1);
      send_word(32'd0, 4'd10, 1'b0, 1'b1);
      send_word(32'd0, 4'd10, 1'b1, 1'b0);
      send_word(32'hFFFF_FFFF, 4'd0, 1'b0, 1'b0);
      send_word(32'hFFFF_FFFF, 4'd0, 1'b1, 1'b0);
      send_word(32'hFFFF_FFFF, 4'd10, 1'b1, 1'b1);
      send_word(32'hFFFF_FFFF, 4'd15, 1'b0, 1'b1);
      send_word(32'hFFFF_FFFF, 4'd3, 1'b0, 1'b0);
      send_word(32'hDEAD_BEEF, 4'd4, 1'b1, 1'b0);
      back_to_back = 1'b1;
      send_word(32'd1000000000, 4'd0, 1'b0, 1'b1);
      send_word(32'd1000000000, 4'd10, 1'b0, 1'b1);
      send_word(32'h00F0_0012, 4'd4, 1'b1, 1'b1);
      send_word(32'h8000_0000, 4'd0, 1'b1, 1'b0);
      send_word(32'd7, 4'd1, 1'b0, 1'b0);
      back_to_back = 1'b0;
      send_word(32'd12345, 4'd8, 1'b0, 1'b1);
      send_word(32'd12345, 4'd8, 1'b0, 1'b0);
      send_word(32'h0000_ABCD, 4'd11, 1'b1, 1'b0);
      send_word(32'd100, 4'd2, 1'b0, 1'b1);
      send_word(32'h7FFF_FFFF, 4'd9, 1'b0, 1'b1);
      send_word(32'd9, 4'd0, 1'b1, 1'b0);
      send_word(32'd15, 4'd0, 1'b1, 1'b1);
      drain_chars();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            back_to_back = !back_to_back;
         end
         if (i == RANDOM_WORDS / 2) begin
            drain_chars();
         end
         case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = $urandom_range(0, 99);
            2: value = $urandom >> $urandom_range(0, 31);
            default: begin
               scaled = longint'(10) ** $urandom_range(0, 9);
               scaled = scaled * $urandom_range(0, 4);
               value  = scaled[31:0];
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            field_width = rnf_pkg::FWIDTH_WIDTH'($urandom_range(0, 15));
         end else begin
            field_width = rnf_pkg::FWIDTH_WIDTH'($urandom_range(0, 10));
         end
         send_word(value, field_width, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      drain_chars();
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
